/* rtl/core/tilf_pkg.sv */
// ----------------------------------------------------------------------------
// tilf_pkg
// Shared types, constants and arithmetic helpers of the ion fraction lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package tilf_pkg;

    localparam int ADDR_W       = 13;
    localparam int ION_COUNT    = 3;
    localparam int BANK_COUNT   = 8;
    localparam int EXP_BITS     = 20;
    localparam int EPS_Q24      = 17;              // 1e-6 in Q8.24
    localparam logic [31:0] LOG2_TEN_Q30 = 32'd3566893132;

    // pipeline: input register is stage 1, result register is the last stage
    localparam int STAGE_COUNT  = 30;

    typedef enum logic {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } command_t;

    typedef enum logic [2:0] {
        REG_REDSHIFT_POS = 3'd0,
        REG_TEMP_MIN     = 3'd1,
        REG_TEMP_MAX     = 3'd2,
        REG_TEMP_INV     = 3'd3,
        REG_DENS_MIN     = 3'd4,
        REG_DENS_MAX     = 3'd5,
        REG_DENS_INV     = 3'd6
    } reg_index_t;

    typedef struct packed {
        logic              valid;
        logic [1:0]        sel;
        logic [ADDR_W-1:0] addr;
        logic [31:0]       value;
    } write_req_t;

    // 2^(-2^-idx) in Q0.32, by repeated integer square root starting at 0.5
    function automatic logic [31:0] exp_root(input int idx);
        logic [63:0] root;
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] bitv;
        int          k;
        root = 64'h8000_0000;
        for (k = 1; k <= idx; k++) begin
            rem  = root << 32;
            res  = '0;
            bitv = 64'h1 << 62;
            while (bitv > rem) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (rem >= res + bitv) begin
                    rem = rem - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            root = res;
        end
        return root[31:0];
    endfunction

    // a*(1-f) + b*f with f in Q.24, rounded half up, floor division
    function automatic logic signed [31:0] lerp(input logic signed [31:0] a,
                                                input logic signed [31:0] b,
                                                input logic [24:0] f);
        logic signed [25:0] fa;
        logic signed [25:0] fb;
        logic signed [58:0] sum;
        fa  = $signed({1'b0, 25'(25'h100_0000 - f)});
        fb  = $signed({1'b0, f});
        sum = 59'(a) * 59'(fa) + 59'(b) * 59'(fb) + 59'sd8388608;
        return 32'(sum >>> 24);
    endfunction

endpackage

`default_nettype wire

/* rtl/core/tilf_channels.sv */
// ----------------------------------------------------------------------------
// tilf channels
// Valid/ready request and result channels of the ion fraction lookup.
// ----------------------------------------------------------------------------
`default_nettype none

interface tilf_request_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [1:0]  ion_select;
    logic [12:0] entry_address;
    logic [31:0] entry_value;
    logic [31:0] log_temperature;
    logic [31:0] log_density;

    modport source (output valid, command, ion_select, entry_address, entry_value,
                    log_temperature, log_density, input ready);
    modport sink   (input valid, command, ion_select, entry_address, entry_value,
                    log_temperature, log_density, output ready);
endinterface

interface tilf_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] singly_ionized_fraction;
    logic [31:0] doubly_ionized_fraction;
    logic [31:0] triply_ionized_fraction;
    logic        redshift_out_of_range;

    modport source (output valid, singly_ionized_fraction, doubly_ionized_fraction,
                    triply_ionized_fraction, redshift_out_of_range, input ready);
    modport sink   (input valid, singly_ionized_fraction, doubly_ionized_fraction,
                    triply_ionized_fraction, redshift_out_of_range, output ready);
endinterface

`default_nettype wire

/* rtl/core/tilf_axis.sv */
// ----------------------------------------------------------------------------
// tilf_axis
// Clamp a log coordinate to the grid and split it into cell and weight.
// Three register stages: offset, partial products, cell select.
// ----------------------------------------------------------------------------
`default_nettype none

module tilf_axis #(
    parameter int POINTS = 32
) (
    input  logic                       clk,
    input  logic                       advance,
    input  logic signed [31:0]         x,
    input  logic signed [31:0]         lo,
    input  logic signed [31:0]         hi,
    input  logic [31:0]                inv,
    output logic [$clog2(POINTS)-1:0]  cell_idx,
    output logic [24:0]                weight
);
    import tilf_pkg::*;

    localparam int CW = $clog2(POINTS);

    logic signed [32:0] top;
    logic signed [32:0] x_lo;
    logic signed [32:0] x_cl;
    logic signed [33:0] diff;
    logic [31:0]        diff_reg;
    logic [47:0]        prod_hi_reg;
    logic [47:0]        prod_lo_reg;
    logic [48:0]        pos;
    logic [24:0]        whole;

    always_comb
    begin
        top  = 33'(hi) - 33'(EPS_Q24);
        x_lo = (33'(x) < 33'(lo)) ? 33'(lo) : 33'(x);
        x_cl = (x_lo > top) ? top : x_lo;
        diff = 34'(x_cl) - 34'(lo);
        pos  = 49'(prod_hi_reg) + 49'(prod_lo_reg >> 16);
        whole = pos[48:24];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            // empty range puts the clamp below lo: treat as position zero
            diff_reg    <= diff[33] ? '0 : diff[31:0];
            prod_hi_reg <= 48'(diff_reg) * 48'(inv[31:16]);
            prod_lo_reg <= 48'(diff_reg) * 48'(inv[15:0]);
            if (whole > 25'(POINTS - 2))
            begin
                cell_idx <= CW'(POINTS - 2);
                weight   <= 25'h100_0000;
            end
            else
            begin
                cell_idx <= whole[CW-1:0];
                weight   <= {1'b0, pos[23:0]};
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tilf_banks.sv */
// ----------------------------------------------------------------------------
// tilf_banks
// Three ion tables, each split eight ways by the parity of the redshift,
// density and temperature index, so all eight cell corners are read together.
// ----------------------------------------------------------------------------
`default_nettype none

module tilf_banks #(
    parameter int REDSHIFT_POINTS = 8,
    parameter int TEMP_POINTS     = 32,
    parameter int DENSITY_POINTS  = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                advance,
    input  tilf_pkg::write_req_t                wr,
    input  logic [$clog2(REDSHIFT_POINTS)-1:0]  zc,
    input  logic [$clog2(DENSITY_POINTS)-1:0]   dc,
    input  logic [$clog2(TEMP_POINTS)-1:0]      tc,
    output logic [31:0]                         rd_data [tilf_pkg::ION_COUNT][tilf_pkg::BANK_COUNT]
);
    import tilf_pkg::*;

    localparam int ZCW = $clog2(REDSHIFT_POINTS);
    localparam int DCW = $clog2(DENSITY_POINTS);
    localparam int TCW = $clog2(TEMP_POINTS);
    localparam int ZH  = (ZCW > 1) ? ZCW - 1 : 1;
    localparam int DH  = (DCW > 1) ? DCW - 1 : 1;
    localparam int TH  = (TCW > 1) ? TCW - 1 : 1;
    localparam int BAW = ZH + DH + TH;
    localparam int BANK_DEPTH = 1 << BAW;

    localparam int PLANE = TEMP_POINTS * DENSITY_POINTS;
    localparam int TABLE = REDSHIFT_POINTS * PLANE;
    localparam int SP = ADDR_W + $clog2(PLANE);
    localparam int SD = ADDR_W + $clog2(TEMP_POINTS);
    localparam longint unsigned RP = ((64'd1 << SP) + PLANE - 1) / PLANE;
    localparam longint unsigned RD = ((64'd1 << SD) + TEMP_POINTS - 1) / TEMP_POINTS;

    // write decode, stage 2
    logic              w2_valid_reg;
    logic [1:0]        w2_sel_reg;
    logic [31:0]       w2_value_reg;
    logic [ZCW-1:0]    w2_z_reg;
    logic [ADDR_W-1:0] w2_rem_reg;
    // stage 3
    logic              w3_valid_reg;
    logic [1:0]        w3_sel_reg;
    logic [31:0]       w3_value_reg;
    logic [ZCW-1:0]    w3_z_reg;
    logic [DCW-1:0]    w3_d_reg;
    logic [TCW-1:0]    w3_t_reg;
    // stage 4
    logic              w4_valid_reg;
    logic [1:0]        w4_sel_reg;
    logic [31:0]       w4_value_reg;
    logic [2:0]        w4_bank_reg;
    logic [BAW-1:0]    w4_addr_reg;

    logic [63:0]       zq;
    logic [63:0]       dq;
    logic              w_ok;
    logic [BAW-1:0]    raddr [BANK_COUNT];

    always_comb
    begin
        zq   = (64'(wr.addr) * 64'(RP)) >> SP;
        dq   = (64'(w2_rem_reg) * 64'(RD)) >> SD;
        w_ok = wr.valid && (wr.sel < 2'(ION_COUNT)) && (32'(wr.addr) < 32'(TABLE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w2_valid_reg <= 1'b0;
            w3_valid_reg <= 1'b0;
            w4_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            w2_valid_reg <= w_ok;
            w3_valid_reg <= w2_valid_reg;
            w4_valid_reg <= w3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            w2_sel_reg   <= wr.sel;
            w2_value_reg <= wr.value;
            w2_z_reg     <= ZCW'(zq);
            w2_rem_reg   <= ADDR_W'(64'(wr.addr) - zq * 64'(PLANE));

            w3_sel_reg   <= w2_sel_reg;
            w3_value_reg <= w2_value_reg;
            w3_z_reg     <= w2_z_reg;
            w3_d_reg     <= DCW'(dq);
            w3_t_reg     <= TCW'(64'(w2_rem_reg) - dq * 64'(TEMP_POINTS));

            w4_sel_reg   <= w3_sel_reg;
            w4_value_reg <= w3_value_reg;
            w4_bank_reg  <= {w3_z_reg[0], w3_d_reg[0], w3_t_reg[0]};
            w4_addr_reg  <= {ZH'(w3_z_reg >> 1), DH'(w3_d_reg >> 1), TH'(w3_t_reg >> 1)};
        end
    end

    // per bank, pick the corner coordinate whose parity matches the bank
    for (genvar b = 0; b < BANK_COUNT; b++)
    begin : g_raddr
        logic [ZCW-1:0] zs;
        logic [DCW-1:0] ds;
        logic [TCW-1:0] ts;
        always_comb
        begin
            zs = (zc[0] == b[2]) ? zc : ZCW'(zc + 1'b1);
            ds = (dc[0] == b[1]) ? dc : DCW'(dc + 1'b1);
            ts = (tc[0] == b[0]) ? tc : TCW'(tc + 1'b1);
            raddr[b] = {ZH'(zs >> 1), DH'(ds >> 1), TH'(ts >> 1)};
        end
    end

    for (genvar s = 0; s < ION_COUNT; s++)
    begin : g_table
        for (genvar b = 0; b < BANK_COUNT; b++)
        begin : g_bank
            logic [31:0] mem [BANK_DEPTH];
            logic [31:0] rdata_reg;

            always_ff @(posedge clk)
            begin
                if (advance)
                begin
                    if (w4_valid_reg && (w4_sel_reg == 2'(s)) && (w4_bank_reg == 3'(b)))
                    begin
                        mem[w4_addr_reg] <= w4_value_reg;
                    end
                    rdata_reg <= mem[raddr[b]];
                end
            end

            assign rd_data[s][b] = rdata_reg;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/tilf_exp10.sv */
// ----------------------------------------------------------------------------
// tilf_exp10
// 10^x for Q8.24 x into Q1.31, as 2^(x*log2 10): one multiply stage, one
// stage per fraction bit of the exponent, then the integer shift.
// ----------------------------------------------------------------------------
`default_nettype none

module tilf_exp10 (
    input  logic               clk,
    input  logic               advance,
    input  logic signed [31:0] x,
    output logic [31:0]        fraction
);
    import tilf_pkg::*;

    logic [32:0] acc_reg   [EXP_BITS+1];
    logic [19:0] bits_reg  [EXP_BITS+1];
    logic [5:0]  shamt_reg [EXP_BITS+1];
    logic        pos_reg   [EXP_BITS+1];
    logic        big_reg   [EXP_BITS+1];

    logic [31:0] nx;
    logic [63:0] m;

    always_comb
    begin
        nx = 32'(33'sd0 - 33'(x));
        m  = 64'(nx) * 64'(LOG2_TEN_Q30);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            acc_reg[0]   <= 33'h1_0000_0000;
            bits_reg[0]  <= m[53:34];
            shamt_reg[0] <= 6'(m[59:54] + 6'd1);
            pos_reg[0]   <= !x[31];
            big_reg[0]   <= (m[63:54] >= 10'd40);
        end
    end

    for (genvar i = 1; i <= EXP_BITS; i++)
    begin : g_step
        localparam logic [31:0] FACTOR = exp_root(i);
        logic [64:0] prod;

        always_comb
        begin
            prod = 65'(acc_reg[i-1]) * 65'(FACTOR);
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                acc_reg[i]   <= bits_reg[i-1][EXP_BITS-i] ? prod[64:32] : acc_reg[i-1];
                bits_reg[i]  <= bits_reg[i-1];
                shamt_reg[i] <= shamt_reg[i-1];
                pos_reg[i]   <= pos_reg[i-1];
                big_reg[i]   <= big_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (pos_reg[EXP_BITS])
            begin
                fraction <= 32'h8000_0000;
            end
            else if (big_reg[EXP_BITS])
            begin
                fraction <= '0;
            end
            else
            begin
                fraction <= 32'(acc_reg[EXP_BITS] >> shamt_reg[EXP_BITS]);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/trilinear_ion_fraction_lookup_core.sv */
// ----------------------------------------------------------------------------
// trilinear_ion_fraction_lookup_core
// Trilinear lookup of three log ion fraction tables, converted to linear.
// ----------------------------------------------------------------------------
// One request enters per cycle while the pipeline advances. A query result
// passes through 30 pipeline stages (input register, axis clamp/multiply,
// banked table read, three lerp stages, a 22 stage 10^x unit); table writes
// give no result and commit in request order, so a query sees every write
// taken before it. The tables are split eight ways by index parity, so all
// eight corners of a cell come out of the block RAMs in one read. When the
// result register is full and not taken the whole pipeline holds. The
// configuration registers must only change while no query is in flight.
`default_nettype none

module trilinear_ion_fraction_lookup_core #(
    parameter int REDSHIFT_POINTS = 8,
    parameter int TEMP_POINTS     = 32,
    parameter int DENSITY_POINTS  = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    tilf_request_if.sink   request,
    tilf_result_if.source  result
);
    import tilf_pkg::*;

    localparam int ZCW  = $clog2(REDSHIFT_POINTS);
    localparam int DCW  = $clog2(DENSITY_POINTS);
    localparam int TCW  = $clog2(TEMP_POINTS);
    localparam int LAST = STAGE_COUNT;

    // configuration
    logic signed [31:0] zpos_reg;
    logic signed [31:0] tmin_reg;
    logic signed [31:0] tmax_reg;
    logic [31:0]        tinv_reg;
    logic signed [31:0] dmin_reg;
    logic signed [31:0] dmax_reg;
    logic [31:0]        dinv_reg;
    reg_index_t         windex;

    logic advance;
    logic take;

    logic        qv_reg   [1:LAST];
    logic        flag_reg [1:LAST];
    logic        wv1_reg;
    logic [1:0]  sel1_reg;
    logic [12:0] addr1_reg;
    logic [31:0] value1_reg;
    logic signed [31:0] temp1_reg;
    logic signed [31:0] dens1_reg;

    logic             flag_in;
    logic [ZCW-1:0]   zc;
    logic [24:0]      zw;
    logic [DCW-1:0]   dc4;
    logic [TCW-1:0]   tc4;
    logic [24:0]      dw4;
    logic [24:0]      tw4;
    write_req_t       wr;

    logic [31:0] rd_data [ION_COUNT][BANK_COUNT];
    logic        dpar5_reg;
    logic        tpar5_reg;
    logic [24:0] dw5_reg;
    logic [24:0] dw6_reg;
    logic [24:0] tw5_reg;
    logic [24:0] tw6_reg;
    logic [24:0] tw7_reg;

    logic signed [31:0] zl_reg [ION_COUNT][2][2];
    logic signed [31:0] dl_reg [ION_COUNT][2];
    logic signed [31:0] tl_reg [ION_COUNT];
    logic [31:0]        frac   [ION_COUNT];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign windex = reg_index_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zpos_reg <= '0;
            tmin_reg <= '0;
            tmax_reg <= '0;
            tinv_reg <= '0;
            dmin_reg <= '0;
            dmax_reg <= '0;
            dinv_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (windex)
                REG_REDSHIFT_POS: zpos_reg <= pwdata;
                REG_TEMP_MIN:     tmin_reg <= pwdata;
                REG_TEMP_MAX:     tmax_reg <= pwdata;
                REG_TEMP_INV:     tinv_reg <= pwdata;
                REG_DENS_MIN:     dmin_reg <= pwdata;
                REG_DENS_MAX:     dmax_reg <= pwdata;
                REG_DENS_INV:     dinv_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (windex)
            REG_REDSHIFT_POS: prdata = zpos_reg;
            REG_TEMP_MIN:     prdata = tmin_reg;
            REG_TEMP_MAX:     prdata = tmax_reg;
            REG_TEMP_INV:     prdata = tinv_reg;
            REG_DENS_MIN:     prdata = dmin_reg;
            REG_DENS_MAX:     prdata = dmax_reg;
            REG_DENS_INV:     prdata = dinv_reg;
            default:          prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    assign advance       = !qv_reg[LAST] || result.ready;
    assign request.ready = advance;
    assign take          = request.valid && advance;

    // redshift cell and weight come straight from the position register
    assign flag_in = zpos_reg[31] || (zpos_reg[30:24] > 7'(REDSHIFT_POINTS - 2));
    assign zc      = ZCW'(zpos_reg[30:24]);
    assign zw      = {1'b0, zpos_reg[23:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wv1_reg <= 1'b0;
            for (int i = 1; i <= LAST; i++)
            begin
                qv_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            wv1_reg   <= take && (request.command == CMD_WRITE);
            qv_reg[1] <= take && (request.command == CMD_QUERY);
            for (int i = 2; i <= LAST; i++)
            begin
                qv_reg[i] <= qv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sel1_reg    <= request.ion_select;
            addr1_reg   <= request.entry_address;
            value1_reg  <= request.entry_value;
            temp1_reg   <= request.log_temperature;
            dens1_reg   <= request.log_density;
            flag_reg[1] <= flag_in;
            for (int i = 2; i <= LAST; i++)
            begin
                flag_reg[i] <= flag_reg[i-1];
            end
        end
    end

    // ---------------- axes: stage 1 to stage 4 ----------------
    tilf_axis #(.POINTS(DENSITY_POINTS)) u_dens_axis (
        .clk      (clk),
        .advance  (advance),
        .x        (dens1_reg),
        .lo       (dmin_reg),
        .hi       (dmax_reg),
        .inv      (dinv_reg),
        .cell_idx (dc4),
        .weight   (dw4)
    );

    tilf_axis #(.POINTS(TEMP_POINTS)) u_temp_axis (
        .clk      (clk),
        .advance  (advance),
        .x        (temp1_reg),
        .lo       (tmin_reg),
        .hi       (tmax_reg),
        .inv      (tinv_reg),
        .cell_idx (tc4),
        .weight   (tw4)
    );

    // ---------------- tables: read issued at stage 4 ----------------
    assign wr = '{valid: wv1_reg, sel: sel1_reg, addr: addr1_reg, value: value1_reg};

    tilf_banks #(
        .REDSHIFT_POINTS (REDSHIFT_POINTS),
        .TEMP_POINTS     (TEMP_POINTS),
        .DENSITY_POINTS  (DENSITY_POINTS)
    ) u_banks (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .wr      (wr),
        .zc      (zc),
        .dc      (dc4),
        .tc      (tc4),
        .rd_data (rd_data)
    );

    // ---------------- interpolation: stages 5 to 8 ----------------
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dpar5_reg <= dc4[0];
            tpar5_reg <= tc4[0];
            dw5_reg   <= dw4;
            tw5_reg   <= tw4;
            dw6_reg   <= dw5_reg;
            tw6_reg   <= tw5_reg;
            tw7_reg   <= tw6_reg;
            for (int s = 0; s < ION_COUNT; s++)
            begin
                for (int kd = 0; kd < 2; kd++)
                begin
                    for (int kt = 0; kt < 2; kt++)
                    begin
                        // corner (kz,kd,kt) sits in bank of its index parities
                        zl_reg[s][kd][kt] <= lerp(
                            rd_data[s][{zc[0], dpar5_reg ^ kd[0], tpar5_reg ^ kt[0]}],
                            rd_data[s][{!zc[0], dpar5_reg ^ kd[0], tpar5_reg ^ kt[0]}],
                            zw);
                    end
                end
                for (int kt = 0; kt < 2; kt++)
                begin
                    dl_reg[s][kt] <= lerp(zl_reg[s][0][kt], zl_reg[s][1][kt], dw6_reg);
                end
                tl_reg[s] <= lerp(dl_reg[s][0], dl_reg[s][1], tw7_reg);
            end
        end
    end

    // ---------------- 10^x: stage 8 to result register ----------------
    for (genvar s = 0; s < ION_COUNT; s++)
    begin : g_exp
        tilf_exp10 u_exp10 (
            .clk      (clk),
            .advance  (advance),
            .x        (tl_reg[s]),
            .fraction (frac[s])
        );
    end

    assign result.valid                   = qv_reg[LAST];
    assign result.redshift_out_of_range   = flag_reg[LAST];
    assign result.singly_ionized_fraction = flag_reg[LAST] ? '0 : frac[0];
    assign result.doubly_ionized_fraction = flag_reg[LAST] ? '0 : frac[1];
    assign result.triply_ionized_fraction = flag_reg[LAST] ? '0 : frac[2];

endmodule

`default_nettype wire

/* tb/sv/tb_trilinear_ion_fraction_lookup_core.sv */
// ----------------------------------------------------------------------------
// tb_trilinear_ion_fraction_lookup_core
// Fills the three ion tables and runs table-write and query requests under
// several grid settings and handshake idle profiles. The result of every
// query is checked against a fixed-point model of the trilinear lookup and
// of the 10^x conversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_trilinear_ion_fraction_lookup_core;
    import tilf_pkg::*;

    localparam int NZ       = 8;
    localparam int NT       = 32;
    localparam int ND       = 32;
    localparam int ENTRIES  = NZ * NT * ND;
    localparam longint ONE  = 64'sd16777216;

    typedef struct {
        logic [31:0] singly;
        logic [31:0] doubly;
        logic [31:0] triply;
        logic        z_out;
    } fraction_t;

    class fraction_scoreboard;
        int                 tbl[3][ENTRIES];
        longint             zpos, tmin, tmax, dmin, dmax;
        longint unsigned    tinv, dinv;
        longint unsigned    roots[EXP_BITS + 1];
        fraction_t          pending[$];
        int                 errors;

        function new();
            roots[0] = 64'h8000_0000;
            for (int i = 1; i <= EXP_BITS; i++)
                roots[i] = int_sqrt(roots[i - 1] << 32);
            zpos = 0; tmin = 0; tmax = 0; dmin = 0; dmax = 0;
            tinv = 0; dinv = 0; errors = 0;
        endfunction

        function longint unsigned int_sqrt(longint unsigned n);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= r + b) begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        function void set_reg(reg_index_t idx, logic [31:0] v);
            case (idx)
                REG_REDSHIFT_POS: zpos = longint'($signed(v));
                REG_TEMP_MIN:     tmin = longint'($signed(v));
                REG_TEMP_MAX:     tmax = longint'($signed(v));
                REG_TEMP_INV:     tinv = longint'(v);
                REG_DENS_MIN:     dmin = longint'($signed(v));
                REG_DENS_MAX:     dmax = longint'($signed(v));
                REG_DENS_INV:     dinv = longint'(v);
                default: ;
            endcase
        endfunction

        function void grid_cell(longint x, longint lo, longint hi, longint unsigned inv,
                                int npts, output int cell_idx, output longint w);
            longint          d;
            longint unsigned ud;
            longint unsigned t;
            if (x < lo) x = lo;
            if (x > hi - EPS_Q24) x = hi - EPS_Q24;
            d = x - lo;
            if (d < 0) d = 0;
            ud = longint'(d);
            t = ud * (inv >> 16) + ((ud * (inv & 64'hFFFF)) >> 16);
            if ((t >> 24) > longint'(npts - 2)) begin
                cell_idx = npts - 2;
                w = ONE;
            end else begin
                cell_idx = int'(t >> 24);
                w = longint'(t & 64'hFF_FFFF);
            end
        endfunction

        function longint blend(longint a, longint b, longint f);
            longint v;
            v = a * (ONE - f) + b * f + (ONE >>> 1);
            return v >>> 24;
        endfunction

        function logic [31:0] pow10(longint x);
            longint unsigned m;
            longint unsigned n;
            longint unsigned acc;
            if (x >= 0) return 32'h8000_0000;
            m = longint'(-x) * 64'd3566893132;
            n = m >> 54;
            if (n >= 40) return 32'h0;
            acc = 64'h1 << 32;
            for (int i = 1; i <= EXP_BITS; i++)
                if (m[54 - i]) acc = (acc * roots[i]) >> 32;
            return 32'(acc >> (n + 1));
        endfunction

        function void note_request(command_t cmd, logic [1:0] sel, logic [12:0] addr,
                                   logic [31:0] val, logic [31:0] lt, logic [31:0] ld);
            fraction_t       r;
            int              zc, dc, tc, i0, i1;
            longint          zw, dw, tw, lo, hi;
            longint          v[2];
            logic [31:0]     f[3];
            if (cmd == CMD_WRITE) begin
                if (sel < 3 && addr < ENTRIES) tbl[sel][addr] = $signed(val);
                return;
            end
            if (zpos < 0 || (zpos >>> 24) > NZ - 2) begin
                r = '{32'h0, 32'h0, 32'h0, 1'b1};
                pending.push_back(r);
                return;
            end
            zc = int'(zpos >>> 24);
            zw = zpos & 64'hFF_FFFF;
            grid_cell(longint'($signed(ld)), dmin, dmax, dinv, ND, dc, dw);
            grid_cell(longint'($signed(lt)), tmin, tmax, tinv, NT, tc, tw);
            for (int s = 0; s < 3; s++) begin
                for (int k = 0; k < 2; k++) begin
                    i0 = tc + k + dc * NT + zc * NT * ND;
                    i1 = i0 + NT;
                    lo = blend(tbl[s][i0], tbl[s][i0 + NT * ND], zw);
                    hi = blend(tbl[s][i1], tbl[s][i1 + NT * ND], zw);
                    v[k] = blend(lo, hi, dw);
                end
                f[s] = pow10(blend(v[0], v[1], tw));
            end
            r = '{f[0], f[1], f[2], 1'b0};
            pending.push_back(r);
        endfunction

        function void check_result(fraction_t got);
            fraction_t e;
            if (pending.size() == 0) begin
                $error("unexpected result: singly %h", got.singly);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.singly !== e.singly) begin
                $error("singly_ionized_fraction exp %h got %h", e.singly, got.singly);
                errors++;
            end
            if (got.doubly !== e.doubly) begin
                $error("doubly_ionized_fraction exp %h got %h", e.doubly, got.doubly);
                errors++;
            end
            if (got.triply !== e.triply) begin
                $error("triply_ionized_fraction exp %h got %h", e.triply, got.triply);
                errors++;
            end
            if (got.z_out !== e.z_out) begin
                $error("redshift_out_of_range exp %b got %b", e.z_out, got.z_out);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tilf_request_if request ();
    tilf_result_if  result ();

    trilinear_ion_fraction_lookup_core #(
        .REDSHIFT_POINTS (NZ),
        .TEMP_POINTS     (NT),
        .DENSITY_POINTS  (ND)
    ) i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .request (request.source),
        .result  (result.sink)
    );

    fraction_scoreboard lookup_sb;
    int                 src_idle_pct;
    int                 snk_stall_pct;
    bit                 hold_req;
    int                 hold_cnt;

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // result side: random stalls, plus a long hold-off on demand
    always @(posedge clk)
    begin
        if (hold_req) begin
            hold_cnt = 400;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt = hold_cnt - 1;
            result.ready <= 1'b0;
        end else begin
            result.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            lookup_sb.check_result('{result.singly_ionized_fraction,
                                     result.doubly_ionized_fraction,
                                     result.triply_ionized_fraction,
                                     result.redshift_out_of_range});
    end

    task automatic send_request(command_t cmd, logic [1:0] sel, logic [12:0] addr,
                                logic [31:0] val, logic [31:0] lt, logic [31:0] ld);
        while ($urandom_range(99) < src_idle_pct) begin
            request.valid <= 1'b0;
            @(posedge clk);
        end
        request.valid           <= 1'b1;
        request.command         <= cmd;
        request.ion_select      <= sel;
        request.entry_address   <= addr;
        request.entry_value     <= val;
        request.log_temperature <= lt;
        request.log_density     <= ld;
        do
            @(posedge clk);
        while (!request.ready);
        lookup_sb.note_request(cmd, sel, addr, val, lt, ld);
    endtask

    task automatic apb_write(reg_index_t idx, logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        lookup_sb.set_reg(idx, v);
    endtask

    task automatic drain();
        request.valid <= 1'b0;
        while (lookup_sb.pending.size() != 0) @(posedge clk);
        repeat (STAGE_COUNT + 10) @(posedge clk);
    endtask

    task automatic load_grid(logic [31:0] zp, logic [31:0] t0, logic [31:0] t1,
                             logic [31:0] ti, logic [31:0] d0, logic [31:0] d1,
                             logic [31:0] di);
        apb_write(REG_REDSHIFT_POS, zp);
        apb_write(REG_TEMP_MIN, t0);
        apb_write(REG_TEMP_MAX, t1);
        apb_write(REG_TEMP_INV, ti);
        apb_write(REG_DENS_MIN, d0);
        apb_write(REG_DENS_MAX, d1);
        apb_write(REG_DENS_INV, di);
    endtask

    // grid index k of the loaded set: the first lo_cnt points, then the last two
    function automatic int loaded_point(int k, int lo_cnt, int npts);
        return (k < lo_cnt) ? k : npts - 2 + (k - lo_cnt);
    endfunction

    // loads every corner of redshift cells 0 and NZ-2 and of axis cells 0, 1 and
    // the last one
    task automatic fill_tables();
        int a;
        for (int s = 0; s < 3; s++)
            for (int kz = 0; kz < 4; kz++)
                for (int kd = 0; kd < 5; kd++)
                    for (int kt = 0; kt < 5; kt++) begin
                        a = loaded_point(kt, 3, NT) + loaded_point(kd, 3, ND) * NT
                            + loaded_point(kz, 2, NZ) * NT * ND;
                        send_request(CMD_WRITE, 2'(s), 13'(a), log_fraction(), '0, '0);
                    end
    endtask

    // typical log fraction, mostly between -11.5 and +0.5
    function automatic logic [31:0] log_fraction();
        if ($urandom_range(9) == 0) return $urandom;
        return 32'(-longint'($urandom_range(0, 32'h0C00_0000)) + 64'sh0080_0000);
    endfunction

    function automatic logic [31:0] axis_value(longint lo, longint hi);
        longint          span;
        if ($urandom_range(9) < 2 || hi <= lo) return $urandom;
        span = hi - lo + 2 * ONE;
        if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
        return 32'(lo - ONE + longint'($urandom_range(0, 32'(span))));
    endfunction

    // query coordinate whose cell has all its corners loaded
    function automatic logic [31:0] query_axis(longint lo, longint hi,
                                               longint unsigned inv, int npts);
        logic [31:0] v;
        int          c;
        longint      w;
        do begin
            v = axis_value(lo, hi);
            lookup_sb.grid_cell(longint'($signed(v)), lo, hi, inv, npts, c, w);
        end while (c != 0 && c != 1 && c != npts - 2);
        return v;
    endfunction

    task automatic random_phase(int count, int profile);
        case (profile)
            0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
            1: begin src_idle_pct = 86; snk_stall_pct = 0;  end
            2: begin src_idle_pct = 0;  snk_stall_pct = 86; end
            default: begin src_idle_pct = 23; snk_stall_pct = 23; end
        endcase
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 15)
                send_request(CMD_WRITE, 2'($urandom_range(3)), 13'($urandom),
                             log_fraction(), $urandom, $urandom);
            else
                send_request(CMD_QUERY, 2'($urandom_range(3)), 13'($urandom), $urandom,
                             query_axis(lookup_sb.tmin, lookup_sb.tmax, lookup_sb.tinv, NT),
                             query_axis(lookup_sb.dmin, lookup_sb.dmax, lookup_sb.dinv, ND));
        end
        drain();
    endtask

    initial
    begin
        lookup_sb               = new();
        rst_n                   = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        request.valid           = 1'b0;
        request.command         = CMD_WRITE;
        request.ion_select      = '0;
        request.entry_address   = '0;
        request.entry_value     = '0;
        request.log_temperature = '0;
        request.log_density     = '0;
        result.ready            = 1'b0;
        src_idle_pct            = 0;
        snk_stall_pct           = 0;
        hold_req                = 0;
        hold_cnt                = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // queries only reach cells whose corners are loaded here
        fill_tables();
        drain();

        // registers at reset: zero inverse steps, empty ranges
        random_phase(30, 0);

        load_grid(32'h0080_0000, 32'h0300_0000, 32'h0900_0000, 32'd338602,
                  32'hF800_0000, 32'h0200_0000, 32'd203162);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_request(CMD_QUERY, 2'd0, '0, '0, 32'h0300_0000, 32'hF800_0000);
        send_request(CMD_QUERY, 2'd0, '0, '0, 32'h0900_0000, 32'h0200_0000);
        send_request(CMD_QUERY, 2'd3, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(CMD_QUERY, 2'd1, '0, '0, 32'h7FFF_FFFF, 32'h8000_0000);
        send_request(CMD_QUERY, 2'd2, '0, '0, 32'h08FF_FFEF, 32'h01FF_FFEF);
        // ion select 3 is dropped
        send_request(CMD_WRITE, 2'd3, 13'd0, 32'h7FFF_FFFF, '1, '1);
        send_request(CMD_WRITE, 2'd0, 13'd8191, 32'h7FFF_FFFF, '0, '0);
        send_request(CMD_WRITE, 2'd1, 13'd0, 32'h8000_0000, '0, '0);
        send_request(CMD_WRITE, 2'd2, 13'd0, 32'h0000_0000, '0, '0);
        send_request(CMD_QUERY, 2'd0, '0, '0, 32'h0300_0000, 32'hF800_0000);
        send_request(CMD_QUERY, 2'd0, '0, '0, 32'h0301_0000, 32'hF801_0000);
        send_request(CMD_WRITE, 2'd0, 13'd8191, log_fraction(), '0, '0);
        send_request(CMD_WRITE, 2'd1, 13'd0, log_fraction(), '0, '0);
        // fill the pipe while the result side holds off
        hold_req = 1;
        random_phase(120, 1);

        load_grid(32'h06FF_FFFF, 32'h0300_0000, 32'h0900_0000, 32'd338602,
                  32'hF800_0000, 32'h0200_0000, 32'h0);
        random_phase(90, 2);

        // full-range axes, overlarge steps, empty density range
        load_grid(32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                  32'h0200_0000, 32'h0100_0000, 32'hFFFF_FFFF);
        random_phase(80, 3);

        load_grid(32'hFF00_0000, 32'h0300_0000, 32'h0900_0000, 32'd338602,
                  32'hF800_0000, 32'h0200_0000, 32'd203162);
        random_phase(20, 0);
        apb_write(REG_REDSHIFT_POS, 32'h0700_0000);
        random_phase(20, 1);
        apb_write(REG_REDSHIFT_POS, 32'h7FFF_FFFF);
        random_phase(20, 2);

        if (lookup_sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #200000;
        $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
